// ===== rtl/sgdd_pkg.sv =====
// Shared types and constants for the signed gadget digit decomposition block.
package sgdd_pkg;

  localparam int COEF_W     = 54;
  localparam int IDX_W      = 6;
  localparam int LOG_W      = 6;
  localparam int CNT_W      = 6;
  localparam int PROD_W     = LOG_W + CNT_W;
  localparam int VAL_W      = COEF_W + 3;
  localparam int MAX_DIGITS = 54;
  localparam int MAX_LOG    = 32;
  localparam int TOP_BITS   = 54;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COEF_W-1:0] MODULUS_RST     = COEF_W'(1073741824);
  localparam logic [LOG_W-1:0]  LOG_BASE_RST    = LOG_W'(7);
  localparam logic [CNT_W-1:0]  DIGIT_COUNT_RST = CNT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS     = 2'd0,
    REG_LOG_BASE    = 2'd1,
    REG_DIGIT_COUNT = 2'd2
  } cfg_reg_t;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [COEF_W-1:0] q;
    logic [LOG_W-1:0]  g;
    logic [4:0]        g_m1;
    logic [CNT_W-1:0]  cnt;
    logic [LOG_W-1:0]  ign;
    logic [LOG_W-1:0]  ign_m1;
  } cfg_t;

endpackage

// ===== rtl/sgdd_cfg.sv =====
// Configuration registers and the derived digit base, count and rounding width.
module sgdd_cfg
  import sgdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COEF_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  logic [COEF_W-1:0] modulus_r;
  logic [LOG_W-1:0]  log_base_r;
  logic [CNT_W-1:0]  digit_count_r;
  logic [LOG_W-1:0]  g;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [LOG_W-1:0]  ign;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= MODULUS_RST;
      log_base_r    <= LOG_BASE_RST;
      digit_count_r <= DIGIT_COUNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODULUS:     modulus_r     <= wr_data;
        REG_LOG_BASE:    log_base_r    <= wr_data[LOG_W-1:0];
        REG_DIGIT_COUNT: digit_count_r <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (log_base_r == '0) begin
      g = LOG_W'(1);
    end else if (log_base_r > LOG_W'(MAX_LOG)) begin
      g = LOG_W'(MAX_LOG);
    end else begin
      g = log_base_r;
    end
    if (digit_count_r > CNT_W'(MAX_DIGITS)) begin
      cnt = CNT_W'(MAX_DIGITS);
    end else begin
      cnt = digit_count_r;
    end
    prod = PROD_W'(cnt) * PROD_W'(g);
    if (prod >= PROD_W'(TOP_BITS)) begin
      ign = '0;
    end else begin
      ign = LOG_W'(PROD_W'(TOP_BITS) - prod);
    end
  end

  assign cfg.q      = modulus_r;
  assign cfg.g      = g;
  assign cfg.g_m1   = 5'(g - LOG_W'(1));
  assign cfg.cnt    = cnt;
  assign cfg.ign    = ign;
  assign cfg.ign_m1 = ign - LOG_W'(1);

endmodule

// ===== rtl/sgdd_prep.sv =====
// Input register, centering stage and rounding of the ignored low bits.
module sgdd_prep
  import sgdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COEF_W-1:0] in_coeff_a,
  input  logic [COEF_W-1:0] in_coeff_b,
  output logic              prep_valid,
  input  logic              prep_ready,
  output val_t              prep_a,
  output val_t              prep_b
);

  logic              s1_v_r;
  logic              s1_v_nxt;
  logic [COEF_W-1:0] s1_a_r;
  logic [COEF_W-1:0] s1_b_r;
  logic              s2_v_r;
  logic              s2_v_nxt;
  val_t              s2_a_r;
  val_t              s2_b_r;
  logic              s1_ready;
  logic              s2_ready;

  function automatic val_t center(input logic [COEF_W-1:0] t, input logic [COEF_W-1:0] q);
    logic [COEF_W-1:0] half;
    half = q >> 1;
    if (t < half) begin
      return val_t'({3'b000, t});
    end
    return val_t'({3'b000, t}) - val_t'({3'b000, q});
  endfunction

  // Signed rounding: drop the low bits and add back the sign of what was dropped.
  function automatic val_t round_off(input val_t v, input cfg_t c);
    val_t sh;
    logic rb;
    sh = v >>> c.ign;
    rb = (c.ign != '0) ? v[c.ign_m1] : 1'b0;
    return sh + val_t'(rb);
  endfunction

  assign s2_ready = !s2_v_r || prep_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_valid;
    end
    s2_v_nxt = s2_v_r;
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_a_r <= in_coeff_a;
      s1_b_r <= in_coeff_b;
    end
    if (s2_ready && s1_v_r) begin
      s2_a_r <= center(s1_a_r, cfg.q);
      s2_b_r <= center(s1_b_r, cfg.q);
    end
  end

  assign prep_valid = s2_v_r;
  assign prep_a     = round_off(s2_a_r, cfg);
  assign prep_b     = round_off(s2_b_r, cfg);

endmodule

// ===== rtl/sgdd_digit.sv =====
// Digit extractor: one lifted signed digit per cycle to the result reg unless stalled.
module sgdd_digit
  import sgdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              prep_valid,
  output logic              prep_ready,
  input  val_t              prep_a,
  input  val_t              prep_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_digit_index,
  output logic [COEF_W-1:0] out_digit_a,
  output logic [COEF_W-1:0] out_digit_b,
  output logic              out_last
);

  logic              busy_r;
  logic              busy_nxt;
  logic              ov_r;
  logic              ov_nxt;
  val_t              da_r;
  val_t              db_r;
  logic [IDX_W-1:0]  k_r;
  logic [IDX_W-1:0]  oidx_r;
  logic [COEF_W-1:0] oa_r;
  logic [COEF_W-1:0] ob_r;
  logic              olast_r;
  logic              emit;
  logic              is_last;
  logic              load;

  // Low digit as a signed value, with the modulus added when it is negative.
  function automatic logic [COEF_W-1:0] lift(input val_t v, input cfg_t c);
    logic [31:0]       mask;
    logic [31:0]       low;
    logic              neg;
    logic [COEF_W-1:0] ext;
    mask = ~(32'hFFFF_FFFF << c.g);
    low  = v[31:0] & mask;
    neg  = v[c.g_m1];
    if (neg) begin
      ext = {{(COEF_W-32){1'b1}}, low | ~mask};
      return ext + c.q;
    end
    return {{(COEF_W-32){1'b0}}, low};
  endfunction

  function automatic val_t advance(input val_t v, input cfg_t c);
    val_t sh;
    sh = v >>> c.g;
    return sh + val_t'(v[c.g_m1]);
  endfunction

  assign emit       = busy_r && (!ov_r || !out_stall);
  assign is_last    = (k_r + IDX_W'(1)) == cfg.cnt;
  assign prep_ready = !busy_r || (emit && is_last);
  assign load       = prep_valid && prep_ready && (cfg.cnt != '0);

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (emit && is_last) begin
      busy_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      da_r <= prep_a;
      db_r <= prep_b;
      k_r  <= '0;
    end else if (emit) begin
      da_r <= advance(da_r, cfg);
      db_r <= advance(db_r, cfg);
      k_r  <= k_r + IDX_W'(1);
    end
    if (emit) begin
      oidx_r  <= k_r;
      oa_r    <= lift(da_r, cfg);
      ob_r    <= lift(db_r, cfg);
      olast_r <= is_last;
    end
  end

  assign out_valid       = ov_r;
  assign out_digit_index = oidx_r;
  assign out_digit_a     = oa_r;
  assign out_digit_b     = ob_r;
  assign out_last        = olast_r;

endmodule

// ===== rtl/signed_gadget_digit_decompose.sv =====
// Top level of the signed gadget digit decomposition block.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+----------------------
//   input   | in_coeff_a, in_coeff_b                     | in_valid / in_stall
//   result  | out_digit_index, out_digit_a, out_digit_b, | out_valid / out_stall
//           | out_last                                   |
//   config  | cfg_index, cfg_data                        | cfg_valid / cfg_ready
//
// A request yields digit_count results (clamped to 54), one per cycle from the digit extractor while
// the result side does not stall; a request with digit_count zero yields no results.
// The first result passes through the input, centering, digit and result registers in that order.
// Reset is synchronous and clears all valid state; configuration returns to its defaults.
// A stall on the result side holds the result register and backs up through the stages.
module signed_gadget_digit_decompose
  import sgdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COEF_W-1:0]    in_coeff_a,
  input  logic [COEF_W-1:0]    in_coeff_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_digit_index,
  output logic [COEF_W-1:0]    out_digit_a,
  output logic [COEF_W-1:0]    out_digit_b,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  cfg_t cfg;
  logic prep_valid;
  logic prep_ready;
  val_t prep_a;
  val_t prep_b;

  assign cfg_ready = 1'b1;

  sgdd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sgdd_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_coeff_a (in_coeff_a),
    .in_coeff_b (in_coeff_b),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep_a     (prep_a),
    .prep_b     (prep_b)
  );

  sgdd_digit u_digit (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .prep_valid      (prep_valid),
    .prep_ready      (prep_ready),
    .prep_a          (prep_a),
    .prep_b          (prep_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_index (out_digit_index),
    .out_digit_a     (out_digit_a),
    .out_digit_b     (out_digit_b),
    .out_last        (out_last)
  );

endmodule

// ===== sim/tb_signed_gadget_digit_decompose.sv =====
// Testbench for the signed gadget digit decomposition block, with a scoreboard that predicts every digit.
module tb_signed_gadget_digit_decompose;
  import sgdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [COEF_W-1:0] digit_a;
    logic [COEF_W-1:0] digit_b;
    logic              last;
  } digit_t;

  class digit_scoreboard;
    logic [COEF_W-1:0] modulus;
    logic [LOG_W-1:0]  log_base;
    logic [CNT_W-1:0]  digit_count;
    digit_t            expected_digits[$];
    int                errors;

    function new();
      modulus     = MODULUS_RST;
      log_base    = LOG_BASE_RST;
      digit_count = DIGIT_COUNT_RST;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_MODULUS: begin
          modulus = data;
        end
        REG_LOG_BASE: begin
          log_base = data[LOG_W-1:0];
        end
        REG_DIGIT_COUNT: begin
          digit_count = data[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    function logic [63:0] low_signed(logic [63:0] x, int n);
      logic [63:0] m;
      logic [63:0] v;
      m = (64'd1 << n) - 64'd1;
      v = x & m;
      if (v[n-1]) v = v | ~m;
      return v;
    endfunction

    function logic [63:0] shift_signed(logic [63:0] x, int s);
      return $signed(x) >>> s;
    endfunction

    function logic [63:0] centered(logic [63:0] t, logic [63:0] q);
      return (t < (q >> 1)) ? t : t - q;
    endfunction

    function void note_request(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b);
      logic [63:0] q;
      logic [63:0] va;
      logic [63:0] vb;
      logic [63:0] ra;
      logic [63:0] rb;
      digit_t      d;
      int          g;
      int          cnt;
      int          ign;
      int          k;
      q   = {10'd0, modulus};
      g   = log_base;
      cnt = digit_count;
      if (g < 1) g = 1;
      if (g > MAX_LOG) g = MAX_LOG;
      if (cnt > MAX_DIGITS) cnt = MAX_DIGITS;
      if (cnt == 0) return;
      ign = (cnt * g >= TOP_BITS) ? 0 : TOP_BITS - cnt * g;
      va  = centered({10'd0, a}, q);
      vb  = centered({10'd0, b}, q);
      if (ign > 0) begin
        va = shift_signed(va - low_signed(va, ign), ign);
        vb = shift_signed(vb - low_signed(vb, ign), ign);
      end
      for (k = 0; k < cnt; k++) begin
        ra = low_signed(va, g);
        rb = low_signed(vb, g);
        va = shift_signed(va - ra, g);
        vb = shift_signed(vb - rb, g);
        if (ra[63]) ra = ra + q;
        if (rb[63]) rb = rb + q;
        d.index   = k[IDX_W-1:0];
        d.digit_a = ra[COEF_W-1:0];
        d.digit_b = rb[COEF_W-1:0];
        d.last    = (k == cnt - 1);
        expected_digits.push_back(d);
      end
    endfunction

    function void check_result(digit_t got);
      digit_t want;
      if (expected_digits.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit index %0d a %h b %h last %0d", $time,
                 got.index, got.digit_a, got.digit_b, got.last);
        return;
      end
      want = expected_digits.pop_front();
      if (got.index !== want.index) begin
        errors++;
        $display("%0t: digit_index expected %0d actual %0d", $time, want.index, got.index);
      end
      if (got.digit_a !== want.digit_a) begin
        errors++;
        $display("%0t: digit_a expected %h actual %h", $time, want.digit_a, got.digit_a);
      end
      if (got.digit_b !== want.digit_b) begin
        errors++;
        $display("%0t: digit_b expected %h actual %h", $time, want.digit_b, got.digit_b);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COEF_W-1:0]    in_coeff_a = '0;
  logic [COEF_W-1:0]    in_coeff_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     out_digit_index;
  logic [COEF_W-1:0]    out_digit_a;
  logic [COEF_W-1:0]    out_digit_b;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  digit_scoreboard sb = new();
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic [COEF_W-1:0] cur_modulus = MODULUS_RST;

  signed_gadget_digit_decompose dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(in_coeff_a, in_coeff_b);
      if (out_valid && !out_stall)
        sb.check_result('{out_digit_index, out_digit_a, out_digit_b, out_last});
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [COEF_W-1:0] rand54();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[COEF_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] rand_coeff(logic [COEF_W-1:0] q);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5 && q != 0) return rand54() % q;
    if (mode == 6) return (q >> 1) + COEF_W'($urandom_range(0, 3)) - COEF_W'(2);
    if (mode == 7) return ($urandom_range(0, 1) != 0) ? q - COEF_W'(1) : COEF_W'(0);
    return rand54();
  endfunction

  task automatic push_request(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coeff_a <= a;
    in_coeff_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic finish_batch();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic [COEF_W-1:0] q, logic [LOG_W-1:0] lg,
                               logic [CNT_W-1:0] dc);
    logic [COEF_W-1:0] upper;
    upper = rand54();
    cfg_write(REG_MODULUS, q);
    cfg_write(REG_LOG_BASE, {upper[COEF_W-1:LOG_W], lg});
    cfg_write(REG_DIGIT_COUNT, {upper[COEF_W-1:CNT_W], dc});
    cfg_valid   <= 1'b0;
    cur_modulus = q;
  endtask

  task automatic random_phase(bit large_count);
    logic [COEF_W-1:0] q;
    logic [LOG_W-1:0]  lg;
    logic [CNT_W-1:0]  dc;
    int                i;
    case ($urandom_range(0, 3))
      0: q = rand54() | COEF_W'(1);
      1: q = COEF_W'(1) << $urandom_range(1, 53);
      2: q = COEF_W'($urandom_range(2, 1000));
      default: q = rand54();
    endcase
    case ($urandom_range(0, 9))
      0: lg = '0;
      1: lg = LOG_W'($urandom_range(33, 63));
      default: lg = LOG_W'($urandom_range(1, 32));
    endcase
    if (large_count)
      dc = CNT_W'($urandom_range(10, 63));
    else if ($urandom_range(0, 9) == 0)
      dc = '0;
    else
      dc = CNT_W'($urandom_range(1, 6));
    apply_setting(q, lg, dc);
    for (i = 0; i < PHASE_ITEMS; i++) push_request(rand_coeff(q), rand_coeff(q));
    finish_batch();
  endtask

  initial begin
    int p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request('0, '0);
    push_request((cur_modulus >> 1) - COEF_W'(1), cur_modulus >> 1);
    push_request(cur_modulus - COEF_W'(1), COEF_W'(1));
    push_request('1, cur_modulus);
    finish_batch();

    apply_setting('1, LOG_W'(6), CNT_W'(9));
    push_request('1, '0);
    push_request(COEF_W'(1) << 52, (COEF_W'(1) << 53) - COEF_W'(1));
    finish_batch();

    apply_setting(COEF_W'(3), LOG_W'(32), CNT_W'(54));
    push_request(COEF_W'(2), COEF_W'(1));
    finish_batch();

    apply_setting(COEF_W'(2), '0, CNT_W'(2));
    push_request(COEF_W'(1), '0);
    push_request('0, COEF_W'(1));
    finish_batch();

    apply_setting(rand54() | COEF_W'(1), '1, '1);
    push_request(rand54(), rand54());
    finish_batch();

    apply_setting(COEF_W'(1) << 40, LOG_W'(5), '0);
    push_request(rand54(), '1);
    push_request('0, rand54());
    finish_batch();

    cfg_write(REG_UNUSED, rand54());
    apply_setting('0, LOG_W'(1), CNT_W'(1));
    push_request('1, COEF_W'(1));
    finish_batch();

    apply_setting(COEF_W'(1), LOG_W'(27), CNT_W'(2));
    push_request(COEF_W'(1), '0);
    push_request('1, (COEF_W'(1) << 53));
    finish_batch();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1)
        idle_on = 1'b0;
      else
        idle_on = ($urandom_range(0, 3) != 0);
      random_phase(p % 4 == 3);
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sgdd_pkg.sv
rtl/sgdd_cfg.sv
rtl/sgdd_prep.sv
rtl/sgdd_digit.sv
rtl/signed_gadget_digit_decompose.sv
sim/tb_signed_gadget_digit_decompose.sv
